// ----- rtl/glos_pkg.sv -----
package glos_pkg;

   // Map geometry and fixed-point format.
   localparam int MAP_SIDE   = 64;
   localparam int COORD_BITS = $clog2(MAP_SIDE);
   localparam int ADDR_W     = 2 * COORD_BITS;
   localparam int FRAC_BITS  = 8;
   localparam int POS_W      = COORD_BITS + FRAC_BITS;
   // A walk can sit one cell outside the map on either side, so cells carry a sign bit.
   localparam int CELL_W     = COORD_BITS + 2;
   localparam int DIST_W     = FRAC_BITS + 1;
   localparam int PROD_W     = DIST_W + POS_W;
   localparam int SIDE_W     = 32;

   // Register widths and reset values.
   localparam int SIZE_W     = 7;
   localparam int LIMIT_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [SIZE_W-1:0]  MAP_SIZE_RESET   = SIZE_W'(64);
   localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = LIMIT_W'(100);

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      OUT_REACHED = 2'd0,
      OUT_WALL    = 2'd1,
      OUT_LEFT    = 2'd2,
      OUT_LIMIT   = 2'd3
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_STEP_LIMIT = 2'd2
   } csr_index_type;

endpackage

// ----- rtl/glos_req_if.sv -----
interface glos_req_if import glos_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [COORD_BITS-1:0] tile_col;
   logic [COORD_BITS-1:0] tile_row;
   logic                  tile_is_wall;
   logic [POS_W-1:0]      start_x;
   logic [POS_W-1:0]      start_y;
   logic [POS_W-1:0]      end_x;
   logic [POS_W-1:0]      end_y;

   modport source (
      output valid, opcode, tile_col, tile_row, tile_is_wall, start_x, start_y, end_x, end_y,
      input  ready
   );
   modport sink (
      input  valid, opcode, tile_col, tile_row, tile_is_wall, start_x, start_y, end_x, end_y,
      output ready
   );
endinterface

// ----- rtl/glos_rsp_if.sv -----
interface glos_rsp_if import glos_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               visible;
   logic [1:0]         outcome;
   logic [LIMIT_W-1:0] steps_taken;

   modport source (
      output valid, visible, outcome, steps_taken,
      input  ready
   );
   modport sink (
      input  valid, visible, outcome, steps_taken,
      output ready
   );
endinterface

// ----- rtl/grid_line_of_sight_unit.sv -----
// Channel   Direction  Beat contents
// req_bus   in         opcode, tile_col/tile_row/tile_is_wall or start_x/y, end_x/y
// rsp_bus   out        visible, outcome, steps_taken (one beat per query)
// csr_*     in         csr_we, csr_index, csr_wdata (map_width, map_height, step_limit)
//
// After reset a clearing pass writes all 4096 map tiles open, and req_bus.ready stays
// low meanwhile. A tile write goes straight into the map memory.
// A query whose start and end share a cell goes straight to the emit state; otherwise
// two multiplier passes set up the boundary distances, then every cell step goes through
// the shared adder and map read and then through the checks.
// The result waits in an output register; a stalled rsp_bus holds the block in its last state.
module grid_line_of_sight_unit import glos_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   glos_req_if.sink              req_bus,
   glos_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL_X,
      S_MUL_Y,
      S_STEP,
      S_CHECK,
      S_EMIT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [SIZE_W-1:0]  map_width_ff;
   logic [SIZE_W-1:0]  map_height_ff;
   logic [LIMIT_W-1:0] step_limit_ff;

   // Walk state.
   logic [CELL_W-1:0]     cell_col_ff;
   logic [CELL_W-1:0]     cell_row_ff;
   logic [COORD_BITS-1:0] tgt_col_ff;
   logic [COORD_BITS-1:0] tgt_row_ff;
   logic [POS_W-1:0]      adx_ff;
   logic [POS_W-1:0]      ady_ff;
   logic                  neg_x_ff;
   logic                  neg_y_ff;
   logic [DIST_W-1:0]     tx_ff;
   logic [DIST_W-1:0]     ty_ff;
   logic [SIDE_W-1:0]     side_x_ff;
   logic [SIDE_W-1:0]     side_y_ff;
   logic [LIMIT_W-1:0]    step_cnt_ff;
   logic [ADDR_W-1:0]     clr_addr_ff;

   // Pending result and output register.
   outcome_type        res_outcome_ff;
   logic [LIMIT_W-1:0] res_steps_ff;
   logic               rsp_valid_ff;
   logic               rsp_visible_ff;
   logic [1:0]         rsp_outcome_ff;
   logic [LIMIT_W-1:0] rsp_steps_ff;

   // Map memory.
   logic              wall_mem [2**ADDR_W];
   logic              rd_wall_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic              mem_wdata;
   logic [ADDR_W-1:0] rd_addr;

   // Accept-cycle decode.
   logic              req_accept;
   logic [POS_W:0]    dx;
   logic [POS_W:0]    dy;
   logic [POS_W-1:0]  adx_in;
   logic [POS_W-1:0]  ady_in;
   logic [DIST_W-1:0] tx_in;
   logic [DIST_W-1:0] ty_in;
   logic              same_cell;

   // Shared multiplier and adder.
   logic [DIST_W-1:0] mul_a;
   logic [POS_W-1:0]  mul_b;
   logic [PROD_W-1:0] mul_p;
   logic              go_x;
   logic [SIDE_W-1:0] add_a;
   logic [SIDE_W-1:0] add_b;
   logic [SIDE_W-1:0] side_sum_in;
   logic [CELL_W-1:0] cell_col_in;
   logic [CELL_W-1:0] cell_row_in;

   // Checks.
   logic [SIZE_W-1:0] w_lim;
   logic [SIZE_W-1:0] h_lim;
   logic              left_map;
   logic              reached;
   logic              out_free;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   assign dx = {1'b0, req_bus.end_x} - {1'b0, req_bus.start_x};
   assign dy = {1'b0, req_bus.end_y} - {1'b0, req_bus.start_y};
   assign adx_in = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
   assign ady_in = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
   // Distance to the first cell edge in the direction of travel.
   assign tx_in = dx[POS_W] ? {1'b0, req_bus.start_x[FRAC_BITS-1:0]}
                            : DIST_W'(2**FRAC_BITS) - {1'b0, req_bus.start_x[FRAC_BITS-1:0]};
   assign ty_in = dy[POS_W] ? {1'b0, req_bus.start_y[FRAC_BITS-1:0]}
                            : DIST_W'(2**FRAC_BITS) - {1'b0, req_bus.start_y[FRAC_BITS-1:0]};
   assign same_cell = (req_bus.start_x[POS_W-1:FRAC_BITS] == req_bus.end_x[POS_W-1:FRAC_BITS])
                   && (req_bus.start_y[POS_W-1:FRAC_BITS] == req_bus.end_y[POS_W-1:FRAC_BITS]);

   assign mul_a = (state_ff == S_MUL_X) ? tx_ff : ty_ff;
   assign mul_b = (state_ff == S_MUL_X) ? ady_ff : adx_ff;
   assign mul_p = mul_a * mul_b;

   // Ties and a vertical ray (no X motion) both step on Y.
   assign go_x = (adx_ff != '0) && ((ady_ff == '0) || (side_x_ff < side_y_ff));
   assign add_a = go_x ? side_x_ff : side_y_ff;
   assign add_b = go_x ? SIDE_W'({ady_ff, {FRAC_BITS{1'b0}}})
                       : SIDE_W'({adx_ff, {FRAC_BITS{1'b0}}});
   assign side_sum_in = add_a + add_b;
   assign cell_col_in = !go_x ? cell_col_ff
                      : cell_col_ff + (neg_x_ff ? {CELL_W{1'b1}} : CELL_W'(1));
   assign cell_row_in = go_x ? cell_row_ff
                      : cell_row_ff + (neg_y_ff ? {CELL_W{1'b1}} : CELL_W'(1));

   assign w_lim = (map_width_ff > SIZE_W'(MAP_SIDE)) ? SIZE_W'(MAP_SIDE) : map_width_ff;
   assign h_lim = (map_height_ff > SIZE_W'(MAP_SIDE)) ? SIZE_W'(MAP_SIDE) : map_height_ff;
   assign left_map = cell_col_ff[CELL_W-1] || cell_row_ff[CELL_W-1]
                  || (SIZE_W'(cell_col_ff[CELL_W-2:0]) >= w_lim)
                  || (SIZE_W'(cell_row_ff[CELL_W-2:0]) >= h_lim);
   assign reached = (cell_col_ff == CELL_W'(tgt_col_ff)) && (cell_row_ff == CELL_W'(tgt_row_ff));

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Map port: clearing sweep and tile writes share the write side; the walk reads.
   assign mem_we    = (state_ff == S_CLEAR) || (req_accept && (req_bus.opcode == OP_WRITE));
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : {req_bus.tile_row, req_bus.tile_col};
   assign mem_wdata = (state_ff == S_CLEAR) ? 1'b0 : req_bus.tile_is_wall;
   assign rd_addr   = {cell_row_in[COORD_BITS-1:0], cell_col_in[COORD_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wall_mem[mem_waddr] <= mem_wdata;
      end
      rd_wall_ff <= wall_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_SIZE_RESET;
         map_height_ff <= MAP_SIZE_RESET;
         step_limit_ff <= STEP_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_MAP_HEIGHT: map_height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_STEP_LIMIT: step_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In S_EMIT the output register is reloaded below, so the drain is left to it.
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               if (clr_addr_ff == {ADDR_W{1'b1}}) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept && (req_bus.opcode == OP_QUERY)) begin
                  cell_col_ff <= CELL_W'(req_bus.start_x[POS_W-1:FRAC_BITS]);
                  cell_row_ff <= CELL_W'(req_bus.start_y[POS_W-1:FRAC_BITS]);
                  tgt_col_ff  <= req_bus.end_x[POS_W-1:FRAC_BITS];
                  tgt_row_ff  <= req_bus.end_y[POS_W-1:FRAC_BITS];
                  adx_ff      <= adx_in;
                  ady_ff      <= ady_in;
                  neg_x_ff    <= dx[POS_W];
                  neg_y_ff    <= dy[POS_W];
                  tx_ff       <= tx_in;
                  ty_ff       <= ty_in;
                  step_cnt_ff <= '0;
                  if (same_cell) begin
                     res_outcome_ff <= OUT_REACHED;
                     res_steps_ff   <= '0;
                     state_ff       <= S_EMIT;
                  end else begin
                     state_ff <= S_MUL_X;
                  end
               end
            end
            S_MUL_X: begin
               side_x_ff <= SIDE_W'(mul_p);
               state_ff  <= S_MUL_Y;
            end
            S_MUL_Y: begin
               side_y_ff <= SIDE_W'(mul_p);
               if (step_limit_ff == '0) begin
                  res_outcome_ff <= OUT_LIMIT;
                  res_steps_ff   <= '0;
                  state_ff       <= S_EMIT;
               end else begin
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               if (go_x) begin
                  side_x_ff <= side_sum_in;
               end else begin
                  side_y_ff <= side_sum_in;
               end
               cell_col_ff <= cell_col_in;
               cell_row_ff <= cell_row_in;
               step_cnt_ff <= step_cnt_ff + LIMIT_W'(1);
               state_ff    <= S_CHECK;
            end
            S_CHECK: begin
               res_steps_ff <= step_cnt_ff;
               priority if (left_map) begin
                  res_outcome_ff <= OUT_LEFT;
                  state_ff       <= S_EMIT;
               end else if (rd_wall_ff) begin
                  res_outcome_ff <= OUT_WALL;
                  state_ff       <= S_EMIT;
               end else if (reached) begin
                  res_outcome_ff <= OUT_REACHED;
                  state_ff       <= S_EMIT;
               end else if (step_cnt_ff < step_limit_ff) begin
                  state_ff <= S_STEP;
               end else begin
                  res_outcome_ff <= OUT_LIMIT;
                  state_ff       <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_visible_ff <= (res_outcome_ff == OUT_REACHED);
                  rsp_outcome_ff <= res_outcome_ff;
                  rsp_steps_ff   <= res_steps_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.visible     = rsp_visible_ff;
   assign rsp_bus.outcome     = rsp_outcome_ff;
   assign rsp_bus.steps_taken = rsp_steps_ff;

   a_visible_matches_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_visible_ff == (rsp_outcome_ff == OUT_REACHED)))
      else $error("visible flag disagrees with outcome");

   a_step_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ((step_cnt_ff != '0) && (step_cnt_ff <= step_limit_ff)))
      else $error("step count outside the limit during the walk");

   a_one_axis_per_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |->
         ((cell_col_ff != $past(cell_col_ff)) != (cell_row_ff != $past(cell_row_ff))))
      else $error("a step did not move on exactly one axis");

   a_limit_result_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT) && (res_outcome_ff == OUT_LIMIT)) |->
         (res_steps_ff == step_limit_ff))
      else $error("step limit result with a count other than the limit");

endmodule
